FILE: hw/rtl/ffm_pkg.sv
`timescale 1ns / 1ps
// Package for the fair arrival-order mutex: sizes, action and status codes,
// and the structs between the top level and the wait queue. No dependencies.

package ffm_pkg;

    // Sizes of the stored state
    localparam int QUEUE_DEPTH = 64;
    localparam int ID_W        = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed widths of the item fields at the ports
    localparam int ACTION_W = 2;
    localparam int REQ_ID_W = 16;
    localparam int STATUS_W = 3;
    localparam int OWNER_W  = 16;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_FREED   = 3'd2,
        ST_HANDED  = 3'd3,
        ST_QUERY   = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // Requests from the lock logic to the wait queue
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] data;
    } t_q_cmd;

    // What the wait queue reports back
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] n_fill;
        logic [ID_W-1:0]   head_data;
    } t_q_stat;

endpackage

FILE: hw/rtl/fifo_fair_mutex.sv
`timescale 1ns / 1ps
// Fair mutex: grants the lock strictly in arrival order.
// Depends on ffm_pkg and ffm_queue.
//
// Usage: drive i_action and i_requester_id and raise start; the item is
// taken at the rising edge where start is high and busy is low. busy is
// always low, so an item may be issued in every cycle.
// Each item gives one result, shown on o_status, o_owner_id, o_is_locked,
// o_is_holder and o_waiting_count for exactly one cycle while o_done is high.
// An item taken with start is held in the input registers (r_in_vld,
// r_action, r_id), decided against the lock state and the wait queue,
// and its result is held in the output registers while o_done is high.
// Throughput is one item per cycle: each item touches only the lock registers
// and one end of the wait queue, whose head entry is read ahead from the queue memory.
// Reset (synchronous, active low) frees the lock, clears the owner and
// empties the queue; queue memory contents are not cleared.
// The receiver cannot stall: every result is taken in the cycle it is shown.

module fifo_fair_mutex (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ffm_pkg::ACTION_W-1:0]   i_action,
    input  logic [ffm_pkg::REQ_ID_W-1:0]   i_requester_id,
    output logic                           o_done,
    output logic [ffm_pkg::STATUS_W-1:0]   o_status,
    output logic [ffm_pkg::OWNER_W-1:0]    o_owner_id,
    output logic                           o_is_locked,
    output logic                           o_is_holder,
    output logic [ffm_pkg::COUNT_W-1:0]    o_waiting_count
);

    localparam logic [ffm_pkg::FILL_W-1:0] FullFill = ffm_pkg::FILL_W'(ffm_pkg::QUEUE_DEPTH);

    logic                       r_in_vld;
    logic [ffm_pkg::ACTION_W-1:0] r_action;
    logic [ffm_pkg::ID_W-1:0]   r_id;
    logic                       r_lock, n_lock;
    logic [ffm_pkg::ID_W-1:0]   r_owner, n_owner;
    ffm_pkg::t_status           n_status;
    logic                       n_holder;
    ffm_pkg::t_q_cmd            q_cmd;
    ffm_pkg::t_q_stat           q_stat;

    assign busy = 1'b0;

    // Register the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_action <= i_action;
            r_id     <= ffm_pkg::ID_W'(i_requester_id);
        end
    end

    // Decide the action against the lock state and the queue
    always_comb begin
        n_lock     = r_lock;
        n_owner    = r_owner;
        n_status   = ffm_pkg::ST_QUERY;
        n_holder   = 1'b0;
        q_cmd.push = 1'b0;
        q_cmd.pop  = 1'b0;
        q_cmd.data = r_id;
        if (r_in_vld) begin
            case (r_action)
                ffm_pkg::ACT_ACQUIRE: begin
                    if (!r_lock && (q_stat.fill == '0)) begin
                        n_lock   = 1'b1;
                        n_owner  = r_id;
                        n_status = ffm_pkg::ST_GRANTED;
                    end else if (q_stat.fill < FullFill) begin
                        q_cmd.push = 1'b1;
                        n_status   = ffm_pkg::ST_QUEUED;
                    end else begin
                        n_status = ffm_pkg::ST_FULL;
                    end
                end
                ffm_pkg::ACT_RELEASE: begin
                    if (q_stat.fill != '0) begin
                        q_cmd.pop = 1'b1;
                        n_lock    = 1'b1;
                        n_owner   = q_stat.head_data;
                        n_status  = ffm_pkg::ST_HANDED;
                    end else begin
                        n_lock   = 1'b0;
                        n_owner  = '0;
                        n_status = ffm_pkg::ST_FREED;
                    end
                end
                default: begin
                    // query, and the unused code treated as one
                    n_holder = r_lock && (r_owner == r_id);
                    n_status = ffm_pkg::ST_QUERY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock  <= 1'b0;
            r_owner <= '0;
        end else begin
            r_lock  <= n_lock;
            r_owner <= n_owner;
        end
    end

    ffm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // Register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            o_status        <= n_status;
            o_owner_id      <= n_lock ? ffm_pkg::OWNER_W'(n_owner) : '0;
            o_is_locked     <= n_lock;
            o_is_holder     <= n_holder;
            o_waiting_count <= ffm_pkg::COUNT_W'(q_stat.n_fill);
        end
    end

    // Checks
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("item did not give a result two cycles after it was taken");

    a_handed_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ffm_pkg::ST_HANDED)) |-> o_is_locked)
        else $error("handover left the lock free");

    a_grant_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ffm_pkg::ST_GRANTED)) |-> (o_waiting_count == '0))
        else $error("grant given past waiting requesters");

    a_freed_no_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ffm_pkg::ST_FREED)) |-> (!o_is_locked && (o_owner_id == '0)))
        else $error("free reported while lock still held");

endmodule

FILE: hw/rtl/ffm_queue.sv
`timescale 1ns / 1ps
// Circular wait queue of requester ids with a registered head read.
// Depends on ffm_pkg for sizes and the command and status structs.

module ffm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffm_pkg::t_q_cmd  i_cmd,
    output ffm_pkg::t_q_stat o_stat
);

    localparam logic [ffm_pkg::PTR_W-1:0] LastSlot = ffm_pkg::PTR_W'(ffm_pkg::QUEUE_DEPTH - 1);

    logic [ffm_pkg::ID_W-1:0]   r_mem [ffm_pkg::QUEUE_DEPTH];
    logic [ffm_pkg::PTR_W-1:0]  r_head, n_head;
    logic [ffm_pkg::PTR_W-1:0]  r_tail, n_tail;
    logic [ffm_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [ffm_pkg::ID_W-1:0]   r_head_data;

    // Advance the pointers and the fill count
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.push) begin
            n_tail = (r_tail == LastSlot) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end
        if (i_cmd.pop) begin
            n_head = (r_head == LastSlot) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Write at the tail; read ahead at the next head, forwarding a write to the same slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.data;
        end
        if (i_cmd.push && (r_tail == n_head)) begin
            r_head_data <= i_cmd.data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_stat.fill      = r_fill;
    assign o_stat.n_fill    = n_fill;
    assign o_stat.head_data = r_head_data;

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_fill < ffm_pkg::FILL_W'(ffm_pkg::QUEUE_DEPTH)))
        else $error("push into a full wait queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fill != '0))
        else $error("pop from an empty wait queue");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop in the same cycle");

endmodule
